FILE: rtl/packbytes_scanline_pixel_decoder_core_assert.svh
// Assertion macros shared by the checker of the PackBytes scanline decoder.
`ifndef PACKBYTES_SCANLINE_PIXEL_DECODER_CORE_ASSERT_SVH
`define PACKBYTES_SCANLINE_PIXEL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define PBSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbsd assertion failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define PBSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbsd assertion failed");

`endif

FILE: rtl/pbsd_pkg.sv
// Types and constants shared by the PackBytes scanline decoder modules.
package pbsd_pkg;

  // Decoder phase: waiting for a code byte, or inside one of the run kinds.
  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LIT   = 2'd1,
    PH_BYTE  = 2'd2,
    PH_GROUP = 2'd3
  } phase_t;

  // Input commands.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  // Code byte operations (top two bits).
  localparam logic [1:0] OP_LIT   = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_GROUP = 2'd2;
  localparam logic [1:0] OP_QUAD  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_PIXELS    = 3'd1;
  localparam logic [2:0] ST_NONE      = 3'd2;
  localparam logic [2:0] ST_BUSY      = 3'd3;
  localparam logic [2:0] ST_DONE_DROP = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_LINE_WIDTH = 1'b0;
  localparam logic CFG_MULTI_PAL  = 1'b1;

  localparam logic [10:0] WIDTH_RESET = 11'd320;
  localparam logic [10:0] X_MAX       = 11'd2047;
  localparam logic [5:0]  COUNT_MASK  = 6'h3f;

  // Slot offsets of the four pixels in 640 mode.
  localparam logic [3:0] SLOT_A = 4'd8;
  localparam logic [3:0] SLOT_B = 4'd12;
  localparam logic [3:0] SLOT_C = 4'd0;
  localparam logic [3:0] SLOT_D = 4'd4;

  localparam logic [2:0] NPIX_320 = 3'd2;
  localparam logic [2:0] NPIX_640 = 3'd4;

  // What the decoder core hands to the pixel formatter for one item.
  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] x_start;
    logic [10:0] width;
    logic        line_done;
    logic        pull;
    logic [7:0]  pbyte;
    logic [7:0]  mode;
  } core_t;

  // One finished result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pixel_a;
    logic [7:0]  pixel_b;
    logic [7:0]  pixel_c;
    logic [7:0]  pixel_d;
    logic [2:0]  pixel_count;
    logic [10:0] x_start;
    logic [3:0]  in_line_mask;
    logic        line_done;
  } res_t;

endpackage

FILE: rtl/pbsd_core.sv
// Decoder state: code parsing, run counting, pattern store and line position.
module pbsd_core import pbsd_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic [10:0] line_width,
  input  logic        multi_palette,
  output core_t       core
);

  localparam logic [10:0] WMAX = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);

  phase_t      phase_r, phase_nxt;
  logic [8:0]  run_r, run_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [10:0] x_r, x_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  store_r [4];

  logic        store_we;
  logic [1:0]  store_addr;
  logic [10:0] ew;
  logic        is_start, is_data, is_pull;
  logic        data_go, code_go, grp_go, byte_go, pull_go;
  logic [1:0]  opcode;
  logic [6:0]  count7;
  logic [2:0]  fill_inc;
  logic [8:0]  run_after;
  logic        pull_last;
  logic [2:0]  npix;
  logic [11:0] x_sum;
  logic [2:0]  status;

  assign ew       = (line_width > WMAX) ? WMAX : line_width;
  assign is_start = accept && (command == CMD_START);
  assign is_data  = accept && (command == CMD_DATA);
  assign is_pull  = accept && (command == CMD_PULL);
  assign data_go  = is_data && !pend_r;
  assign code_go  = data_go && (phase_r == PH_CODE) && (x_r < ew);
  assign grp_go   = data_go && (phase_r == PH_GROUP);
  assign byte_go  = data_go && ((phase_r == PH_LIT) || (phase_r == PH_BYTE));
  assign pull_go  = is_pull && pend_r;
  assign opcode   = data_byte[7:6];
  assign count7   = {1'b0, data_byte[5:0] & COUNT_MASK} + 7'd1;
  assign fill_inc = fill_r + 3'd1;

  // A group run counts one repeat when the slot wraps; other runs count each byte.
  assign run_after = (phase_r == PH_GROUP) ?
                     ((slot_r == 2'd3) ? run_r - 9'd1 : run_r) : run_r - 9'd1;
  assign pull_last = (run_after == 9'd0);

  assign npix  = mode_r[7] ? NPIX_640 : NPIX_320;
  assign x_sum = {1'b0, x_r} + {9'b0, npix};

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (is_start) begin
      phase_nxt = PH_CODE;
    end else if (code_go) begin
      unique case (opcode) inside
        OP_LIT:           phase_nxt = PH_LIT;
        OP_BYTE, OP_QUAD: phase_nxt = PH_BYTE;
        OP_GROUP:         phase_nxt = PH_GROUP;
        default:          phase_nxt = phase_r;
      endcase
    end else if (pull_go && pull_last) begin
      phase_nxt = PH_CODE;
    end
  end

  // Counters, position, store writes and result fields.
  always_comb begin
    run_nxt    = run_r;
    slot_nxt   = slot_r;
    fill_nxt   = fill_r;
    mode_nxt   = mode_r;
    x_nxt      = x_r;
    pend_nxt   = pend_r;
    store_we   = 1'b0;
    store_addr = 2'd0;
    status     = ST_NONE;
    if (is_start) begin
      mode_nxt = multi_palette ? 8'd0 : data_byte;
      x_nxt    = 11'd0;
      run_nxt  = 9'd0;
      slot_nxt = 2'd0;
      fill_nxt = 3'd0;
      pend_nxt = 1'b0;
      status   = ST_ACCEPTED;
    end else if (is_data) begin
      if (pend_r) begin
        status = ST_BUSY;
      end else if (phase_r == PH_CODE && !code_go) begin
        status = ST_DONE_DROP;
      end else begin
        status = ST_ACCEPTED;
      end
      if (code_go) begin
        run_nxt = (opcode == OP_QUAD) ? {count7, 2'b00} : {2'b00, count7};
        if (opcode == OP_GROUP) begin
          fill_nxt = 3'd0;
        end
      end else if (grp_go) begin
        store_we   = 1'b1;
        store_addr = fill_r[1:0];
        fill_nxt   = fill_inc;
        if (fill_inc >= 3'd4) begin
          fill_nxt = 3'd4;
          slot_nxt = 2'd0;
          pend_nxt = 1'b1;
        end
      end else if (byte_go) begin
        store_we = 1'b1;
        pend_nxt = 1'b1;
      end
    end else if (pull_go) begin
      status  = ST_PIXELS;
      run_nxt = run_after;
      if (phase_r == PH_GROUP) begin
        slot_nxt = slot_r + 2'd1;
      end else if (phase_r == PH_LIT) begin
        pend_nxt = 1'b0;
      end
      if (pull_last) begin
        pend_nxt = 1'b0;
        fill_nxt = 3'd0;
      end
      x_nxt = x_sum[11] ? X_MAX : x_sum[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CODE;
      run_r   <= 9'd0;
      slot_r  <= 2'd0;
      fill_r  <= 3'd0;
      mode_r  <= 8'd0;
      x_r     <= 11'd0;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      slot_r  <= slot_nxt;
      fill_r  <= fill_nxt;
      mode_r  <= mode_nxt;
      x_r     <= x_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Pattern store holds no reset; every entry is written before a pull reads it.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_addr] <= data_byte;
    end
  end

  always_comb begin
    core.status    = status;
    core.x_start   = is_start ? 11'd0 : x_r;
    core.width     = ew;
    core.line_done = (phase_nxt == PH_CODE) && !pend_nxt && (x_nxt >= ew);
    core.pull      = pull_go;
    core.pbyte     = store_r[(phase_r == PH_GROUP) ? slot_r : 2'd0];
    core.mode      = mode_r;
  end

endmodule

FILE: rtl/pbsd_fmt.sv
// Pixel formatter: splits a decoded byte into palette indices and line mask.
module pbsd_fmt import pbsd_pkg::*; (
  input  core_t core,
  output res_t  res
);

  logic [3:0]  pal;
  logic [7:0]  p;
  logic [2:0]  npix;
  logic [3:0]  mask;

  assign pal  = core.mode[3:0];
  assign p    = core.pbyte;
  assign npix = core.pull ? (core.mode[7] ? NPIX_640 : NPIX_320) : 3'd0;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mask[i] = (3'(i) < npix) &&
                (({1'b0, core.x_start} + 12'(i)) < {1'b0, core.width});
    end
  end

  always_comb begin
    res.status       = core.status;
    res.pixel_a      = 8'd0;
    res.pixel_b      = 8'd0;
    res.pixel_c      = 8'd0;
    res.pixel_d      = 8'd0;
    res.pixel_count  = npix;
    res.x_start      = core.x_start;
    res.in_line_mask = mask;
    res.line_done    = core.line_done;
    if (core.pull) begin
      if (core.mode[7]) begin
        res.pixel_a = {pal, SLOT_A | {2'b00, p[7:6]}};
        res.pixel_b = {pal, SLOT_B | {2'b00, p[5:4]}};
        res.pixel_c = {pal, SLOT_C | {2'b00, p[3:2]}};
        res.pixel_d = {pal, SLOT_D | {2'b00, p[1:0]}};
      end else begin
        res.pixel_a = {pal, p[7:4]};
        res.pixel_b = {pal, p[3:0]};
      end
    end
  end

endmodule

FILE: rtl/pbsd_skid.sv
// Two-entry output buffer that decouples result stall from item acceptance.
module pbsd_skid import pbsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  input  logic out_stall,
  output logic full,
  output logic out_valid,
  output res_t out_data
);

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t main_r, skid_r;
  logic pop;

  assign pop = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_v_nxt = 1'b1;
      end else begin
        main_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      main_r <= skid_r;
    end else if (push && (pop || !main_v_r)) begin
      main_r <= push_data;
    end
    if (push && main_v_r && !pop) begin
      skid_r <= push_data;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

FILE: rtl/packbytes_scanline_pixel_decoder_core.sv
// A result item is registered into the output buffer when its item is accepted.
// Throughput: one item per cycle while in_stall is low; decoder state updates in the accepting cycle.
// A two-entry output buffer keeps input accepted while one result waits on out_stall.
// in_stall rises only when both buffer entries are full.
// Synchronous active-low reset: line width 320, single palette, decoder idle at x 0.
module packbytes_scanline_pixel_decoder_core import pbsd_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_pixel_a,
  output logic [7:0]  out_pixel_b,
  output logic [7:0]  out_pixel_c,
  output logic [7:0]  out_pixel_d,
  output logic [2:0]  out_pixel_count,
  output logic [10:0] out_x_start,
  output logic [3:0]  out_in_line_mask,
  output logic        out_line_done
);

  // Configuration registers; the user writes them only while the decoder is idle, the block itself does not enforce it.
  logic [10:0] line_width_r;
  logic        multi_palette_r;

  logic  accept;
  core_t core;
  res_t  res;
  res_t  out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r    <= WIDTH_RESET;
      multi_palette_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: line_width_r    <= cfg_data;
        CFG_MULTI_PAL:  multi_palette_r <= cfg_data[0];
        default:        line_width_r    <= line_width_r;
      endcase
    end
  end

  // An item is taken whenever the output buffer has a free entry.
  assign accept = in_valid && !in_stall;

  // Decoder state and per-item status.
  pbsd_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .command       (in_command),
    .data_byte     (in_data_byte),
    .line_width    (line_width_r),
    .multi_palette (multi_palette_r),
    .core          (core)
  );

  // Turns the decoded byte into pixels and the in-line mask.
  pbsd_fmt u_fmt (
    .core (core),
    .res  (res)
  );

  // Result register with one skid entry behind it.
  pbsd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .out_stall (out_stall),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_data  (out_res)
  );

  assign out_status       = out_res.status;
  assign out_pixel_a      = out_res.pixel_a;
  assign out_pixel_b      = out_res.pixel_b;
  assign out_pixel_c      = out_res.pixel_c;
  assign out_pixel_d      = out_res.pixel_d;
  assign out_pixel_count  = out_res.pixel_count;
  assign out_x_start      = out_res.x_start;
  assign out_in_line_mask = out_res.in_line_mask;
  assign out_line_done    = out_res.line_done;

endmodule

FILE: rtl/pbsd_checker.sv
// Port-level checker for the PackBytes scanline decoder, bound to the top level.
`include "packbytes_scanline_pixel_decoder_core_assert.svh"

module pbsd_checker import pbsd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [7:0]  out_pixel_c,
  input logic [7:0]  out_pixel_d,
  input logic [2:0]  out_pixel_count,
  input logic [3:0]  out_in_line_mask
);

  // A stalled result item keeps out_valid high.
  `PBSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // Items without pixels carry no pixels and an empty mask.
  `PBSD_ASSERT_NOW(a_no_pix, out_valid && (out_status != ST_PIXELS), (out_pixel_count == 3'd0) && (out_in_line_mask == 4'd0))

  // A pixel item carries two or four pixels.
  `PBSD_ASSERT_NOW(a_pix_count, out_valid && (out_status == ST_PIXELS), (out_pixel_count == NPIX_320) || (out_pixel_count == NPIX_640))

  // In two-pixel items the unused slots and mask bits stay clear.
  `PBSD_ASSERT_NOW(a_unused, out_valid && (out_pixel_count != NPIX_640), (out_pixel_c == 8'd0) && (out_pixel_d == 8'd0) && (out_in_line_mask[3:2] == 2'b00))

endmodule

bind packbytes_scanline_pixel_decoder_core pbsd_checker u_pbsd_checker (.*);

FILE: test/scanline_tracker_pkg.sv
`timescale 1ns / 100ps
// Scanline tracker: mirrors the PackBytes decoder state and checks each result item.
package scanline_tracker_pkg;
  import pbsd_pkg::*;

  localparam int MAX_DECODE_WIDTH = 1024;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class scanline_tracker;
    logic [10:0] line_width;
    logic        multi_pal;
    phase_t      phase;
    logic [8:0]  run_left;
    logic [7:0]  pattern_bytes [4];
    logic [1:0]  slot;
    logic [2:0]  fill;
    logic [7:0]  mode;
    logic [10:0] xpos;
    logic        pending;

    res_t        expected_q [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      line_width = WIDTH_RESET;
      multi_pal  = 1'b0;
      phase      = PH_CODE;
      run_left   = '0;
      slot       = '0;
      fill       = '0;
      mode       = '0;
      xpos       = '0;
      pending    = 1'b0;
      for (int k = 0; k < 4; k++) pattern_bytes[k] = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic idx, logic [10:0] val);
      if (idx == CFG_LINE_WIDTH) begin
        line_width = val;
      end else begin
        multi_pal = val[0];
      end
    endfunction

    function logic [10:0] eff_width();
      return (line_width > 11'(MAX_DECODE_WIDTH)) ? 11'(MAX_DECODE_WIDTH) : line_width;
    endfunction

    // Advances the mirrored state by one accepted item and queues the result it causes.
    function void take_item(logic [1:0] cmd, logic [7:0] b);
      res_t        r;
      logic [7:0]  p;
      logic [7:0]  pal;
      logic [10:0] w;
      logic [8:0]  cnt;
      int          nx;
      int          i;
      r = '0;
      r.status = ST_NONE;
      r.x_start = xpos;
      w = eff_width();
      case (cmd)
        CMD_START: begin
          mode = multi_pal ? 8'h00 : b;
          xpos = '0;
          r.x_start = '0;
          phase = PH_CODE;
          run_left = '0;
          slot = '0;
          fill = '0;
          pending = 1'b0;
          r.status = ST_ACCEPTED;
        end
        CMD_DATA: begin
          if (pending) begin
            r.status = ST_BUSY;
          end else if (phase == PH_CODE) begin
            cnt = {3'd0, b[5:0]} + 9'd1;
            if (xpos >= w) begin
              r.status = ST_DONE_DROP;
            end else begin
              r.status = ST_ACCEPTED;
              case (b[7:6])
                OP_LIT: begin
                  phase = PH_LIT;
                  run_left = cnt;
                end
                OP_BYTE: begin
                  phase = PH_BYTE;
                  run_left = cnt;
                end
                OP_GROUP: begin
                  phase = PH_GROUP;
                  run_left = cnt;
                  fill = '0;
                end
                OP_QUAD: begin
                  phase = PH_BYTE;
                  run_left = cnt << 2;
                end
              endcase
            end
          end else if (phase == PH_GROUP) begin
            pattern_bytes[fill[1:0]] = b;
            fill = fill + 3'd1;
            if (fill >= 3'd4) begin
              fill = 3'd4;
              slot = '0;
              pending = 1'b1;
            end
            r.status = ST_ACCEPTED;
          end else begin
            pattern_bytes[0] = b;
            pending = 1'b1;
            r.status = ST_ACCEPTED;
          end
        end
        CMD_PULL: begin
          if (pending) begin
            if (phase == PH_GROUP) begin
              p = pattern_bytes[slot];
              slot = slot + 2'd1;
              if (slot == 2'd0) run_left = run_left - 9'd1;
            end else begin
              p = pattern_bytes[0];
              run_left = run_left - 9'd1;
              if (phase == PH_LIT) pending = 1'b0;
            end
            if (run_left == 9'd0) begin
              pending = 1'b0;
              fill = '0;
              phase = PH_CODE;
            end
            pal = {mode[3:0], 4'h0};
            if (mode[7]) begin
              r.pixel_a = pal | {4'h0, SLOT_A} | {6'd0, p[7:6]};
              r.pixel_b = pal | {4'h0, SLOT_B} | {6'd0, p[5:4]};
              r.pixel_c = pal | {4'h0, SLOT_C} | {6'd0, p[3:2]};
              r.pixel_d = pal | {4'h0, SLOT_D} | {6'd0, p[1:0]};
              r.pixel_count = NPIX_640;
            end else begin
              r.pixel_a = pal | {4'h0, p[7:4]};
              r.pixel_b = pal | {4'h0, p[3:0]};
              r.pixel_count = NPIX_320;
            end
            for (i = 0; i < int'(r.pixel_count); i++) begin
              if (int'(xpos) + i < int'(w)) r.in_line_mask[i] = 1'b1;
            end
            nx = int'(xpos) + int'(r.pixel_count);
            xpos = (nx > int'(X_MAX)) ? X_MAX : 11'(nx);
            r.status = ST_PIXELS;
          end
        end
        default: begin
        end
      endcase
      r.line_done = (phase == PH_CODE) && !pending && (xpos >= w);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned have);
      if (want != have) begin
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, have);
        mismatches++;
      end
    endfunction

    function void check_pixels(res_t got);
      res_t want;
      checked++;
      if (expected_q.size() == 0) begin
        $display("%0t ns: result item expected none, got status %0d x %0d",
                 $time, got.status, got.x_start);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("pixel_a", want.pixel_a, got.pixel_a);
      compare_field("pixel_b", want.pixel_b, got.pixel_b);
      compare_field("pixel_c", want.pixel_c, got.pixel_c);
      compare_field("pixel_d", want.pixel_d, got.pixel_d);
      compare_field("pixel_count", want.pixel_count, got.pixel_count);
      compare_field("x_start", want.x_start, got.x_start);
      compare_field("in_line_mask", want.in_line_mask, got.in_line_mask);
      compare_field("line_done", want.line_done, got.line_done);
    endfunction
  endclass

endpackage

FILE: test/packbytes_scanline_pixel_decoder_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the PackBytes scanline decoder core with random stalls on both sides.
module packbytes_scanline_pixel_decoder_core_test;
  import pbsd_pkg::*;
  import scanline_tracker_pkg::*;

  // A watchdog ends the run after this many cycles in which no item is accepted and no result taken.
  localparam int STALL_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_SEGMENT = 146;
  localparam int NUM_SEGMENTS = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_pixel_a;
  logic [7:0]  out_pixel_b;
  logic [7:0]  out_pixel_c;
  logic [7:0]  out_pixel_d;
  logic [2:0]  out_pixel_count;
  logic [10:0] out_x_start;
  logic [3:0]  out_in_line_mask;
  logic        out_line_done;

  scanline_tracker tracker = new();

  // Idle rates in percent for the sender and the receiver; the main loop changes them.
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 75;
  int unsigned items_sent = 0;
  int unsigned reg_writes = 0;
  int          quiet_cycles = 0;

  // Line widths visited, one per segment: the extremes 0, 1 and 2047 (clamped by the block)
  // together with a spread of ordinary sizes.
  logic [10:0] seg_widths [NUM_SEGMENTS] = '{11'd1, 11'd0, 11'd2047, 11'd16, 11'd1024, 11'd8,
                                              11'd320, 11'd64, 11'd1023, 11'd3, 11'd40,
                                              11'd512};

  packbytes_scanline_pixel_decoder_core #(
    .MAX_WIDTH(MAX_DECODE_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_pixel_a(out_pixel_a),
    .out_pixel_b(out_pixel_b),
    .out_pixel_c(out_pixel_c),
    .out_pixel_d(out_pixel_d),
    .out_pixel_count(out_pixel_count),
    .out_x_start(out_x_start),
    .out_in_line_mask(out_in_line_mask),
    .out_line_done(out_line_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver decides once per cycle, at the falling edge, whether to hold off results.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: at each rising edge the result channel is checked first and then the accepted
  // input item, if any, is handed to the tracker. Both only read values that were settled
  // before the edge, so the order against the block's own processes does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_pixels({out_status, out_pixel_a, out_pixel_b, out_pixel_c, out_pixel_d,
                              out_pixel_count, out_x_start, out_in_line_mask, out_line_done});
      end
      if (in_valid && !in_stall) begin
        tracker.take_item(in_command, in_data_byte);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles, %0d results still awaited",
                 $time, STALL_LIMIT, tracker.expected_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offers one item and returns at the falling edge after it was taken. It is always entered
  // at a falling edge. Idle cycles lower valid first; without them valid stays high, so the
  // next item follows back to back with a single assignment per time step.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    if (cmd != CMD_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // The sender holds off until every expected result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Register writes happen only while nothing is in flight. The enable is lowered again
  // after each write so back-to-back calls never assign it twice in one time step.
  task automatic write_reg(input logic idx, input logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, val);
    reg_writes++;
    @(negedge clk);
  endtask

  // Run lengths are mostly short so that lines end often; now and then one is long.
  function automatic logic [5:0] random_count();
    return ($urandom_range(15) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
  endfunction

  // One well-formed run: the code byte, its data bytes, and the pulls that empty it.
  // Stray data bytes are slipped in now and then while pixels are pending, which the
  // block must drop as busy.
  task automatic emit_run(input logic [1:0] op, input logic [5:0] cnt);
    int i;
    int pulls;
    send_item(CMD_DATA, {op, cnt});
    if (op == OP_LIT) begin
      for (i = 0; i <= int'(cnt); i++) begin
        send_item(CMD_DATA, 8'($urandom));
        if ($urandom_range(15) == 0) send_item(CMD_DATA, 8'($urandom));
        send_item(CMD_PULL, 8'($urandom));
      end
    end else begin
      if (op == OP_GROUP) begin
        repeat (4) send_item(CMD_DATA, 8'($urandom));
      end else begin
        send_item(CMD_DATA, 8'($urandom));
      end
      pulls = (op == OP_BYTE) ? int'(cnt) + 1 : 4 * (int'(cnt) + 1);
      for (i = 0; i < pulls; i++) begin
        if ($urandom_range(31) == 0) send_item(CMD_DATA, 8'($urandom));
        send_item(CMD_PULL, 8'($urandom));
      end
    end
  endtask

  // Random traffic until the item count reaches the goal. Most of it is whole lines built
  // from well-formed runs with random modes and content; the rest is raw noise (the unused
  // command among it) and lines abandoned in the middle of a run.
  task automatic gen_traffic(input int unsigned goal);
    int unsigned pick;
    int unsigned n;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(2'($urandom_range(3)), 8'($urandom));
      end else if (pick < 16) begin
        send_item(CMD_START, 8'($urandom));
        send_item(CMD_DATA, 8'($urandom));
        n = $urandom_range(1, 5);
        repeat (n) send_item($urandom_range(1) ? CMD_DATA : CMD_PULL, 8'($urandom));
      end else begin
        send_item(CMD_START, 8'($urandom));
        n = $urandom_range(1, 6);
        repeat (n) begin
          emit_run(2'($urandom_range(3)), random_count());
          if ($urandom_range(7) == 0) send_item(CMD_PULL, 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    int unsigned seg;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with the reset settings (width 320, single palette).
    // A pull with nothing pending, then the unused command, both answered as no pixels.
    send_item(CMD_PULL, 8'h00);
    send_item(CMD_UNUSED, 8'hff);
    // A 640-mode line on palette 15: literal run of two bytes with a busy drop between.
    send_item(CMD_START, 8'h8f);
    send_item(CMD_DATA, {OP_LIT, 6'd1});
    send_item(CMD_DATA, 8'he4);
    send_item(CMD_DATA, 8'h55);
    send_item(CMD_PULL, 8'h00);
    send_item(CMD_DATA, 8'h1b);
    send_item(CMD_PULL, 8'hff);
    // Single-byte repeat with an all-ones byte.
    send_item(CMD_DATA, {OP_BYTE, 6'd0});
    send_item(CMD_DATA, 8'hff);
    send_item(CMD_PULL, 8'h00);
    // Four-byte group repeated once.
    send_item(CMD_DATA, {OP_GROUP, 6'd0});
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hff);
    send_item(CMD_DATA, 8'ha5);
    send_item(CMD_DATA, 8'h5a);
    repeat (4) send_item(CMD_PULL, 8'h00);
    // A quad run left after two pulls: the new 320-mode line start abandons it.
    send_item(CMD_DATA, {OP_QUAD, 6'd3});
    send_item(CMD_DATA, 8'h3c);
    repeat (2) send_item(CMD_PULL, 8'h00);
    send_item(CMD_START, 8'h07);
    send_item(CMD_PULL, 8'h00);

    // Random part: three idle mixes, each split into segments with their own settings.
    for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 25;
      end else if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_results_drained();
      write_reg(CFG_LINE_WIDTH, seg_widths[seg]);
      write_reg(CFG_MULTI_PAL, 11'(seg % 2));
      // On the widest setting one long quad run fills the clamped line width, so the
      // second run's code byte and the bytes after it are dropped as line complete and
      // its pulls find nothing pending.
      if (seg_widths[seg] == X_MAX) begin
        send_item(CMD_START, {4'h8, 4'($urandom)});
        repeat (2) emit_run(OP_QUAD, COUNT_MASK);
        send_item(CMD_DATA, 8'($urandom));
        send_item(CMD_PULL, 8'h00);
      end
      gen_traffic(ITEMS_PER_SEGMENT * (seg + 1));
    end

    wait_results_drained();
    repeat (8) @(negedge clk);
    $display("Sent %0d items and checked %0d results across %0d register writes,",
             items_sent, tracker.checked, reg_writes);
    $display("covering three idle mixes, widths from 0 to 2047 and both palette modes.");
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
